@@ rtl/ppwt_pkg.sv @@
// Shared types, constants and the trajectory function of the position PID core.
`default_nettype none

package ppwt_pkg;

    localparam int ENC_W       = 13;
    localparam int PHASE_W     = 8;
    localparam int PHASE_LAST  = 199;
    localparam int HALF_COUNTS = 4096;
    localparam int FULL_COUNTS = 8192;
    localparam int SHAFT_MULT  = 75;
    localparam int SHAFT_SHIFT = 7;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_GAIN_P      = 3'd0;
    localparam logic [2:0] REG_GAIN_I      = 3'd1;
    localparam logic [2:0] REG_GAIN_D      = 3'd2;
    localparam logic [2:0] REG_INT_LIMIT   = 3'd3;
    localparam logic [2:0] REG_DRIVE_LIMIT = 3'd4;

    localparam logic [23:0] GAIN_P_RESET      = 24'd12800;
    localparam logic [23:0] GAIN_I_RESET      = 24'd0;
    localparam logic [23:0] GAIN_D_RESET      = 24'd0;
    localparam logic [22:0] INT_LIMIT_RESET   = 23'd2560000;
    localparam logic [14:0] DRIVE_LIMIT_RESET = 15'd8000;

    typedef struct packed {
        logic [23:0] gain_p;
        logic [23:0] gain_i;
        logic [23:0] gain_d;
        logic [22:0] integral_limit;
        logic [14:0] drive_limit;
    } cfg_t;

    typedef enum logic [1:0] {
        MUL_SHAFT,
        MUL_P,
        MUL_I,
        MUL_D
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TURN,
        ST_SHAFT_LO,
        ST_SHAFT_HI,
        ST_ERR,
        ST_INT,
        ST_P_LO,
        ST_P_HI,
        ST_I_LO,
        ST_I_HI,
        ST_D_LO,
        ST_D_HI,
        ST_DIV,
        ST_CLAMP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     take_input;
        logic     upd_turn;
        logic     mul_en;
        logic     mul_first;
        logic     mul_hi;
        mul_sel_t mul_sel;
        logic     calc_err;
        logic     calc_int;
        logic     calc_div;
        logic     calc_clamp;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

    // Triangle setpoint in Q8 degrees: 23040*x/50 truncated toward zero.
    function automatic logic signed [15:0] target_of(input logic [PHASE_W-1:0] p);
        logic [5:0]  mag;
        logic        neg;
        logic [15:0] frac;
        logic [15:0] val;
        begin
            if (p < 8'd50) begin
                mag = p[5:0];
                neg = 1'b0;
            end else if (p <= 8'd100) begin
                mag = 6'(8'd100 - p);
                neg = 1'b0;
            end else if (p < 8'd150) begin
                mag = 6'(p - 8'd100);
                neg = 1'b1;
            end else begin
                mag = 6'(8'd200 - p);
                neg = 1'b1;
            end
            frac = ({8'd0, mag, 2'b00} * 16'd205) >> 10;
            val  = 16'({10'd0, mag} * 16'd460) + frac;
            target_of = neg ? -$signed(val) : $signed(val);
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/ppwt_regs.sv @@
// Configuration register file behind the APB-style port.
`default_nettype none

module ppwt_regs
    import ppwt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] index;

    assign index  = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            case (index)
                REG_GAIN_P:      cfg_next.gain_p         = pwdata[23:0];
                REG_GAIN_I:      cfg_next.gain_i         = pwdata[23:0];
                REG_GAIN_D:      cfg_next.gain_d         = pwdata[23:0];
                REG_INT_LIMIT:   cfg_next.integral_limit = pwdata[22:0];
                REG_DRIVE_LIMIT: cfg_next.drive_limit    = pwdata[14:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p         <= GAIN_P_RESET;
            cfg_reg.gain_i         <= GAIN_I_RESET;
            cfg_reg.gain_d         <= GAIN_D_RESET;
            cfg_reg.integral_limit <= INT_LIMIT_RESET;
            cfg_reg.drive_limit    <= DRIVE_LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (index)
            REG_GAIN_P:      prdata = {8'd0, cfg_reg.gain_p};
            REG_GAIN_I:      prdata = {8'd0, cfg_reg.gain_i};
            REG_GAIN_D:      prdata = {8'd0, cfg_reg.gain_d};
            REG_INT_LIMIT:   prdata = {9'd0, cfg_reg.integral_limit};
            REG_DRIVE_LIMIT: prdata = {17'd0, cfg_reg.drive_limit};
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/ppwt_ctrl.sv @@
// Sequencer that steps the datapath through one control tick.
`default_nettype none

module ppwt_ctrl
    import ppwt_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_TURN;
            ST_TURN:     state_next = ST_SHAFT_LO;
            ST_SHAFT_LO: state_next = ST_SHAFT_HI;
            ST_SHAFT_HI: state_next = ST_ERR;
            ST_ERR:      state_next = ST_INT;
            ST_INT:      state_next = ST_P_LO;
            ST_P_LO:     state_next = ST_P_HI;
            ST_P_HI:     state_next = ST_I_LO;
            ST_I_LO:     state_next = ST_I_HI;
            ST_I_HI:     state_next = ST_D_LO;
            ST_D_LO:     state_next = ST_D_HI;
            ST_D_HI:     state_next = ST_DIV;
            ST_DIV:      state_next = ST_CLAMP;
            ST_CLAMP:    state_next = ST_OUT;
            ST_OUT:      if (stat.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.take_input = s_valid;
            end
            ST_TURN:     cmd.upd_turn = 1'b1;
            ST_SHAFT_LO: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_first = 1'b1;
                cmd.mul_sel   = MUL_SHAFT;
            end
            ST_SHAFT_HI: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_hi  = 1'b1;
                cmd.mul_sel = MUL_SHAFT;
            end
            ST_ERR:      cmd.calc_err = 1'b1;
            ST_INT:      cmd.calc_int = 1'b1;
            ST_P_LO: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_first = 1'b1;
                cmd.mul_sel   = MUL_P;
            end
            ST_P_HI: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_hi  = 1'b1;
                cmd.mul_sel = MUL_P;
            end
            ST_I_LO: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_I;
            end
            ST_I_HI: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_hi  = 1'b1;
                cmd.mul_sel = MUL_I;
            end
            ST_D_LO: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_D;
            end
            ST_D_HI: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_hi  = 1'b1;
                cmd.mul_sel = MUL_D;
            end
            ST_DIV:      cmd.calc_div   = 1'b1;
            ST_CLAMP:    cmd.calc_clamp = 1'b1;
            ST_OUT:      cmd.load_out   = stat.out_free;
            default:     cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ppwt_dp.sv @@
// Datapath: trajectory, encoder unwrap, shared multiplier, PID and output register.
`default_nettype none

module ppwt_dp
    import ppwt_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cmd_t               cmd,
    output stat_t                   stat,
    input  wire cfg_t               cfg,
    input  wire logic [ENC_W-1:0]   s_encoder_angle,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_drive_current,
    output logic signed [31:0]      m_shaft_angle,
    output logic signed [15:0]      m_setpoint
);

    // Control state.
    logic [PHASE_W-1:0] phase_reg,     phase_next;
    logic [ENC_W-1:0]   prev_enc_reg,  prev_enc_next;
    logic signed [31:0] turn_reg,      turn_next;
    logic signed [23:0] integral_reg,  integral_next;
    logic signed [32:0] prev_err_reg,  prev_err_next;
    logic               m_valid_reg,   m_valid_next;

    // Per-request working registers.
    logic [ENC_W-1:0]   enc_reg;
    logic signed [15:0] target_reg;
    logic signed [31:0] shaft_reg;
    logic signed [32:0] err_reg;
    logic signed [33:0] derr_reg;
    logic signed [63:0] acc_reg,       acc_next;
    logic signed [47:0] quot_reg;
    logic signed [15:0] drive_reg;

    logic signed [15:0] out_drive_reg;
    logic signed [31:0] out_shaft_reg;
    logic signed [15:0] out_target_reg;

    logic signed [13:0] diff_raw;
    logic signed [13:0] diff_adj;
    logic signed [31:0] shaft_val;
    logic signed [33:0] int_sum;
    logic signed [33:0] int_lim;
    logic signed [33:0] int_clamped;
    logic signed [47:0] quot_val;
    logic signed [47:0] drv_lim;
    logic signed [15:0] drive_val;

    logic signed [24:0] mul_a;
    logic signed [33:0] mul_b_full;
    logic signed [17:0] mul_b;
    logic signed [42:0] prod;
    logic signed [63:0] prod_aligned;

    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_drive_current = out_drive_reg;
    assign m_shaft_angle   = out_shaft_reg;
    assign m_setpoint      = out_target_reg;

    // Encoder unwrap.
    always_comb begin
        diff_raw = $signed({1'b0, enc_reg}) - $signed({1'b0, prev_enc_reg});
        if (diff_raw < -14'sd4096) begin
            diff_adj = diff_raw + 14'(FULL_COUNTS);
        end else if (diff_raw > 14'sd4096) begin
            diff_adj = diff_raw - 14'(FULL_COUNTS);
        end else begin
            diff_adj = diff_raw;
        end
    end

    // Shared 25 x 18 multiplier, second operand taken 17 bits at a time.
    always_comb begin
        case (cmd.mul_sel)
            MUL_SHAFT: begin
                mul_a      = 25'(SHAFT_MULT);
                mul_b_full = {{2{turn_reg[31]}}, turn_reg};
            end
            MUL_P: begin
                mul_a      = $signed({1'b0, cfg.gain_p});
                mul_b_full = {err_reg[32], err_reg};
            end
            MUL_I: begin
                mul_a      = $signed({1'b0, cfg.gain_i});
                mul_b_full = {{10{integral_reg[23]}}, integral_reg};
            end
            MUL_D: begin
                mul_a      = $signed({1'b0, cfg.gain_d});
                mul_b_full = derr_reg;
            end
            default: begin
                mul_a      = '0;
                mul_b_full = '0;
            end
        endcase
        mul_b = cmd.mul_hi ? {mul_b_full[33], mul_b_full[33:17]}
                           : $signed({1'b0, mul_b_full[16:0]});
    end

    assign prod = mul_a * mul_b;

    always_comb begin
        if (cmd.mul_hi) begin
            prod_aligned = {{4{prod[42]}}, prod, 17'd0};
        end else begin
            prod_aligned = {{21{prod[42]}}, prod};
        end
        acc_next = acc_reg;
        if (cmd.mul_en) begin
            acc_next = (cmd.mul_first ? 64'sd0 : acc_reg) + prod_aligned;
        end
    end

    assign shaft_val = acc_reg[31+SHAFT_SHIFT:SHAFT_SHIFT];

    // Integral with symmetric clamp.
    always_comb begin
        int_sum = {{10{integral_reg[23]}}, integral_reg} + {err_reg[32], err_reg};
        int_lim = $signed({11'd0, cfg.integral_limit});
        if (int_sum > int_lim) begin
            int_clamped = int_lim;
        end else if (int_sum < -int_lim) begin
            int_clamped = -int_lim;
        end else begin
            int_clamped = int_sum;
        end
    end

    // Division by 65536 truncating toward zero, then drive clamp.
    always_comb begin
        quot_val = acc_reg[63:16];
        if (acc_reg[63] && (acc_reg[15:0] != 16'd0)) begin
            quot_val = acc_reg[63:16] + 48'sd1;
        end
        drv_lim = $signed({33'd0, cfg.drive_limit});
        if (quot_reg > drv_lim) begin
            drive_val = drv_lim[15:0];
        end else if (quot_reg < -drv_lim) begin
            drive_val = 16'(-drv_lim);
        end else begin
            drive_val = quot_reg[15:0];
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        prev_enc_next = prev_enc_reg;
        turn_next     = turn_reg;
        integral_next = integral_reg;
        prev_err_next = prev_err_reg;
        m_valid_next  = m_valid_reg;
        if (cmd.take_input) begin
            phase_next = (phase_reg == PHASE_W'(PHASE_LAST)) ? '0 : phase_reg + 1'b1;
        end
        if (cmd.upd_turn) begin
            turn_next     = turn_reg + {{18{diff_adj[13]}}, diff_adj};
            prev_enc_next = enc_reg;
        end
        if (cmd.calc_int) begin
            integral_next = int_clamped[23:0];
            prev_err_next = err_reg;
        end
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= '0;
            prev_enc_reg <= '0;
            turn_reg     <= '0;
            integral_reg <= '0;
            prev_err_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            prev_enc_reg <= prev_enc_next;
            turn_reg     <= turn_next;
            integral_reg <= integral_next;
            prev_err_reg <= prev_err_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (cmd.take_input) begin
            enc_reg    <= s_encoder_angle;
            target_reg <= target_of(phase_reg);
        end
        if (cmd.calc_err) begin
            shaft_reg <= shaft_val;
            err_reg   <= {{17{target_reg[15]}}, target_reg}
                         - {shaft_val[31], shaft_val};
        end
        if (cmd.calc_int) begin
            derr_reg <= {err_reg[32], err_reg} - {prev_err_reg[32], prev_err_reg};
        end
        if (cmd.calc_div) begin
            quot_reg <= quot_val;
        end
        if (cmd.calc_clamp) begin
            drive_reg <= drive_val;
        end
        if (cmd.load_out) begin
            out_drive_reg  <= drive_reg;
            out_shaft_reg  <= shaft_reg;
            out_target_reg <= target_reg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/position_pid_with_trajectory_core.sv @@
// Position PID core: a request is accepted in idle and goes through the unwrap, error,
// integral, divide and clamp steps and eight passes through the one shared 25 x 18 multiplier.
// No new request is taken until the last result is loaded, and loading waits while the
// result side stalls. A finished result waits in the output register while the
// next request is taken. Reset (aresetn low at a clock edge) restores the register defaults
// and clears the phase, encoder history, turn count, integral and previous error.
`default_nettype none

module position_pid_with_trajectory_core
    import ppwt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [ENC_W-1:0]  s_encoder_angle,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic signed [15:0]     m_drive_current,
    output logic signed [31:0]     m_shaft_angle,
    output logic signed [15:0]     m_setpoint
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    ppwt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ppwt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ppwt_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .cfg             (cfg),
        .s_encoder_angle (s_encoder_angle),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_current (m_drive_current),
        .m_shaft_angle   (m_shaft_angle),
        .m_setpoint      (m_setpoint)
    );

endmodule

`default_nettype wire
